FILE: hdl/cpmd_pkg.sv
// Shared types and constants for the clamped PID motor drive.
`timescale 1ns / 1ps

package cpmd_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_DEAD_OFFSET = 3'd5
  } cpmd_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic signed [15:0] GainPropRst   = 16'sd2560;  // 0.625 in Q4.12
  localparam logic signed [15:0] GainIntegRst  = 16'sd0;
  localparam logic signed [15:0] GainDerivRst  = 16'sd0;
  localparam logic [14:0]        IntegLimitRst = 15'd8000;   // 500.0 in Q11.4
  localparam logic [11:0]        DriveLimitRst = 12'd500;
  localparam logic [11:0]        DeadOffsetRst = 12'd0;

  // Input item.
  typedef struct packed {
    logic signed [15:0] gyro_rate;
    logic signed [15:0] tilt_angle;
  } cpmd_in_t;

  // Result item.
  typedef struct packed {
    logic        direction;
    logic [12:0] duty;
  } cpmd_out_t;

  // Operands after the state update.
  typedef struct packed {
    logic signed [15:0] rate;
    logic signed [15:0] integ;
    logic signed [16:0] diff;
  } cpmd_opnd_t;

  // Q.12 products.
  typedef struct packed {
    logic signed [31:0] prop;
    logic signed [31:0] integ;
    logic signed [32:0] deriv;
  } cpmd_prod_t;

  // Gains as one bundle.
  typedef struct packed {
    logic signed [15:0] prop;
    logic signed [15:0] integ;
    logic signed [15:0] deriv;
  } cpmd_gains_t;

endpackage

FILE: hdl/cpmd_integ.sv
// State stage: clamped angle integral and rate difference.
`timescale 1ns / 1ps

module cpmd_integ import cpmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  cpmd_in_t    data_i,
  input  logic [14:0] integ_limit_i,
  output logic        valid_o,
  input  logic        ready_i,
  output cpmd_opnd_t  opnd_o
);

  logic               valid_q;
  logic signed [15:0] integ_q, integ_d;
  logic signed [15:0] prev_q;
  logic signed [15:0] rate_q;
  logic signed [16:0] diff_q, diff_d;
  logic signed [16:0] sum;
  logic signed [16:0] lim_pos, lim_neg;
  logic               take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    lim_pos = signed'({2'b00, integ_limit_i});
    lim_neg = -lim_pos;
    sum     = 17'(integ_q) + 17'(data_i.tilt_angle);
    priority if (sum > lim_pos) begin
      integ_d = lim_pos[15:0];
    end else if (sum < lim_neg) begin
      integ_d = lim_neg[15:0];
    end else begin
      integ_d = sum[15:0];
    end
    diff_d = 17'(data_i.gyro_rate) - 17'(prev_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      if (ready_o) valid_q <= valid_i;
      if (take) begin
        integ_q <= integ_d;
        prev_q  <= data_i.gyro_rate;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rate_q <= data_i.gyro_rate;
      diff_q <= diff_d;
    end
  end

  assign valid_o     = valid_q;
  assign opnd_o.rate  = rate_q;
  assign opnd_o.integ = integ_q;
  assign opnd_o.diff  = diff_q;

  // Freshly updated integral stays inside the clamp window.
  a_integ_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (17'(integ_q) <= signed'({2'b00, integ_limit_i}))
          && (17'(integ_q) >= -signed'({2'b00, integ_limit_i})))
    else $error("integral outside clamp window");

endmodule

FILE: hdl/cpmd_mult.sv
// Product stage: the three gain multiplies, registered.
`timescale 1ns / 1ps

module cpmd_mult import cpmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  cpmd_opnd_t  opnd_i,
  input  cpmd_gains_t gains_i,
  output logic        valid_o,
  input  logic        ready_i,
  output cpmd_prod_t  prod_o
);

  logic       valid_q;
  cpmd_prod_t prod_q, prod_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod_d.prop  = 32'(opnd_i.rate) * 32'(gains_i.prop);
    prod_d.integ = 32'(opnd_i.integ) * 32'(gains_i.integ);
    prod_d.deriv = 33'(opnd_i.diff) * 33'(gains_i.deriv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) prod_q <= prod_d;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

FILE: hdl/cpmd_out.sv
// Output stage: sum, truncate toward zero, clamp, direction and duty.
`timescale 1ns / 1ps

module cpmd_out import cpmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  cpmd_prod_t  prod_i,
  input  logic [11:0] drive_limit_i,
  input  logic [11:0] dead_offset_i,
  output logic        valid_o,
  input  logic        ready_i,
  output cpmd_out_t   data_o
);

  logic               valid_q;
  cpmd_out_t          data_q, data_d;
  logic signed [34:0] acc;
  logic [34:0]        abs_acc;
  logic [22:0]        mag_full;
  logic [11:0]        mag;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    acc      = 35'(prod_i.prop) + 35'(prod_i.integ) + 35'(prod_i.deriv);
    abs_acc  = acc[34] ? 35'(-acc) : 35'(acc);
    mag_full = abs_acc[34:12];
    mag      = (mag_full > {11'd0, drive_limit_i}) ? drive_limit_i : mag_full[11:0];
    data_d.direction = acc[34] && (mag != 12'd0);
    data_d.duty      = {1'b0, mag} + {1'b0, dead_offset_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Duty never drops below the dead-band offset.
  a_duty_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.duty >= {1'b0, dead_offset_i}))
    else $error("duty below dead offset");

  // Forward direction only with a nonzero magnitude.
  a_dir_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && data_q.direction) |-> (data_q.duty != {1'b0, dead_offset_i}))
    else $error("forward direction with zero magnitude");

endmodule

FILE: hdl/clamped_pid_motor_drive_unit.sv
// Top level of the clamped PID motor drive: config registers and three-stage pipe.
`timescale 1ns / 1ps

//  Channel  Signals                                  Direction  Moves
//  in       in_valid_i, in_stall_o, in_data_i        sink       gyro_rate, tilt_angle
//  out      out_valid_o, out_stall_i, out_data_o     source     direction, duty
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i          sink       register writes
//
// One transfer in per cycle while in_stall_o is low, one result per item, through
// the registered stages (state update, multiplies, sum/clamp into the result register).
// The integral and previous-rate update is a single add-and-clamp in the
// first stage, so back-to-back items see each other's state.
// Reset (rst_ni low, async) clears the state, empties the pipe and loads
// the register defaults. A stalled output holds its stage; stages behind it
// keep filling, and in_stall_o rises only once every stage is occupied.

module clamped_pid_motor_drive_unit import cpmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cpmd_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpmd_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  cpmd_gains_t gains_q;
  logic [14:0] integ_limit_q;
  logic [11:0] drive_limit_q;
  logic [11:0] dead_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.prop  <= GainPropRst;
      gains_q.integ <= GainIntegRst;
      gains_q.deriv <= GainDerivRst;
      integ_limit_q <= IntegLimitRst;
      drive_limit_q <= DriveLimitRst;
      dead_offset_q <= DeadOffsetRst;
    end else if (cfg_we_i) begin
      unique case (cpmd_reg_e'(cfg_idx_i))
        REG_GAIN_PROP:   gains_q.prop  <= cfg_data_i;
        REG_GAIN_INTEG:  gains_q.integ <= cfg_data_i;
        REG_GAIN_DERIV:  gains_q.deriv <= cfg_data_i;
        REG_INTEG_LIMIT: integ_limit_q <= cfg_data_i[14:0];
        REG_DRIVE_LIMIT: drive_limit_q <= cfg_data_i[11:0];
        REG_DEAD_OFFSET: dead_offset_q <= cfg_data_i[11:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // Pipeline.
  logic       s1_valid, s1_ready, s2_valid, s2_ready, s3_ready;
  cpmd_opnd_t opnd;
  cpmd_prod_t prod;

  cpmd_integ u_integ (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (s1_ready),
    .data_i        (in_data_i),
    .integ_limit_i (integ_limit_q),
    .valid_o       (s1_valid),
    .ready_i       (s2_ready),
    .opnd_o        (opnd)
  );

  cpmd_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .opnd_i  (opnd),
    .gains_i (gains_q),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .prod_o  (prod)
  );

  cpmd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s2_valid),
    .ready_o       (s3_ready),
    .prod_i        (prod),
    .drive_limit_i (drive_limit_q),
    .dead_offset_i (dead_offset_q),
    .valid_o       (out_valid_o),
    .ready_i       (!out_stall_i),
    .data_o        (out_data_o)
  );

  assign in_stall_o = !s1_ready;

  // Input backs up only when every stage holds an item and the output is stalled.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid && s2_valid))
    else $error("input stalled with room in the pipe");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the clamped PID motor drive: predictor, scoreboard, stimulus.
`timescale 1ns / 1ps

module testbench;
  import cpmd_pkg::*;

  // Nominal pipe depth is three; the drain pause adds margin.
  localparam int unsigned PipeSettle = 6;
  // Watchdog limit; the slowest legal run stays well below it.
  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned PhaseItems = 190;
  localparam int unsigned NumPhases  = 8;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  // Predicts each drive command from the sample stream and keeps the
  // commands still owed by the block, oldest first.
  class drive_scoreboard;
    int        gain_p, gain_i, gain_d;
    int        integ_lim, drive_lim, dead_off;
    int        angle_sum, last_rate;
    int        errors;
    cpmd_out_t pending_drive[$];

    function new();
      gain_p    = int'(GainPropRst);
      gain_i    = int'(GainIntegRst);
      gain_d    = int'(GainDerivRst);
      integ_lim = int'(IntegLimitRst);
      drive_lim = int'(DriveLimitRst);
      dead_off  = int'(DeadOffsetRst);
      angle_sum = 0;
      last_rate = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_GAIN_PROP:   gain_p = int'(signed'(val));
        REG_GAIN_INTEG:  gain_i = int'(signed'(val));
        REG_GAIN_DERIV:  gain_d = int'(signed'(val));
        REG_INTEG_LIMIT: integ_lim = int'(val[14:0]);
        REG_DRIVE_LIMIT: drive_lim = int'(val[11:0]);
        REG_DEAD_OFFSET: dead_off = int'(val[11:0]);
        default: ;
      endcase
    endfunction

    function cpmd_out_t predict_drive(cpmd_in_t s);
      int        rate, angle, sum, diff;
      longint    acc, mag;
      cpmd_out_t cmd;
      rate  = int'(signed'(s.gyro_rate));
      angle = int'(signed'(s.tilt_angle));
      // integral with symmetric clamp
      sum = angle_sum + angle;
      if (sum > integ_lim) begin
        sum = integ_lim;
      end else if (sum < -integ_lim) begin
        sum = -integ_lim;
      end
      angle_sum = sum;
      diff      = rate - last_rate;
      last_rate = rate;
      acc = longint'(gain_p) * rate + longint'(gain_i) * angle_sum
          + longint'(gain_d) * diff;
      // Q.12 to counts, toward zero
      mag = (acc < 0) ? ((-acc) >>> 12) : (acc >>> 12);
      if (mag > longint'(drive_lim)) mag = longint'(drive_lim);
      cmd.direction = (acc < 0) && (mag != 0);
      cmd.duty      = 13'(mag + longint'(dead_off));
      return cmd;
    endfunction

    function void note_sample(cpmd_in_t s);
      pending_drive.push_back(predict_drive(s));
    endfunction

    task report_mismatch(string what);
      $display("%0t: drive mismatch: %s", $time, what);
      errors++;
    endtask

    task check_drive(cpmd_out_t got);
      cpmd_out_t want;
      if (pending_drive.size() == 0) begin
        report_mismatch($sformatf("command dir=%0b duty=%0d with none owed",
                                  got.direction, got.duty));
      end else begin
        want = pending_drive.pop_front();
        if (got.direction !== want.direction)
          report_mismatch($sformatf("direction %0b, want %0b", got.direction,
                                    want.direction));
        if (got.duty !== want.duty)
          report_mismatch($sformatf("duty %0d, want %0d", got.duty, want.duty));
      end
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  cpmd_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cpmd_out_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  drive_scoreboard sb = new();

  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  bit          push_up    = 1'b0;  // which rail the integral gets driven toward

  clamped_pid_motor_drive_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("clamped_pid_motor_drive_unit test failed");
      $finish;
    end
  end

  // Receiver backpressure: switches between free-running, light, heavy and
  // periodic stall modes at random intervals.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ((cycles % 7) < 3);
    endcase
  end

  // Every result transfer is checked against the oldest owed command.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_drive(out_data);
  end

  // One sample transfer. The sender runs in bursts; between bursts valid
  // drops for a random gap, sometimes none at all.
  task send_sample(cpmd_in_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
  endtask

  task send_pair(logic [15:0] rate, logic [15:0] angle);
    cpmd_in_t s;
    s.gyro_rate  = rate;
    s.tilt_angle = angle;
    send_sample(s);
  endtask

  // Hold off the sender until every owed command has come back.
  task wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_drive.size() != 0) @(posedge clk);
    repeat (PipeSettle) @(posedge clk);
  endtask

  task write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Loads all six registers; optionally pokes the unmapped indexes too.
  task set_config(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                  logic [15:0] il, logic [15:0] dl, logic [15:0] dof, bit spare);
    write_cfg(REG_GAIN_PROP, gp);
    write_cfg(REG_GAIN_INTEG, gi);
    write_cfg(REG_GAIN_DERIV, gd);
    write_cfg(REG_INTEG_LIMIT, il);
    write_cfg(REG_DRIVE_LIMIT, dl);
    write_cfg(REG_DEAD_OFFSET, dof);
    if (spare) begin
      write_cfg(RegSpareLo, 16'($urandom));
      write_cfg(RegSpareHi, 16'hFFFF);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of sensor-like small samples, full-range noise, rail values and
  // long one-sided tilt that drives the integral into its clamp.
  function cpmd_in_t rand_sample();
    cpmd_in_t    s;
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 5) begin
      s.gyro_rate  = 16'($urandom_range(0, 400) - 200);
      s.tilt_angle = 16'($urandom_range(0, 400) - 200);
    end else if (m < 8) begin
      s.gyro_rate  = 16'($urandom);
      s.tilt_angle = 16'($urandom);
    end else if (m == 8) begin
      case ($urandom_range(0, 3))
        0: s.gyro_rate = 16'h7FFF;
        1: s.gyro_rate = 16'h8000;
        2: s.gyro_rate = 16'h0000;
        default: s.gyro_rate = 16'hFFFF;
      endcase
      s.tilt_angle = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    end else begin
      s.gyro_rate  = 16'($urandom);
      s.tilt_angle = {push_up ? 8'h7F : 8'h81, 8'($urandom)};
    end
    return s;
  endfunction

  initial begin
    logic [15:0] gp, gi, gd, il, dl, dof;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: gain 0.625 on rate only, drive clamp 500.
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h7FFF, 16'h7FFF);   // saturates positive
    send_pair(16'h8000, 16'h8000);   // saturates negative
    send_pair(16'hFFFF, 16'h0000);   // tiny negative truncates to zero: reverse
    send_pair(16'h0001, 16'h0000);
    send_pair(16'hFFFE, 16'h0000);   // just reaches one count negative
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'hAAAA, 16'h5555);
    wait_idle();

    // Full-scale gains and limits; upper data bits must be dropped.
    set_config(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'h7FFF, 16'h7FFF);
    send_pair(16'h8000, 16'h7FFF);   // largest rate step down
    send_pair(16'h7FFF, 16'h7FFF);   // largest rate step up, integral at rail
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h8000, 16'h8000);
    wait_idle();

    // Zero clamps: integral pinned at zero, magnitude forced to zero.
    set_config(16'h0001, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'd123, 1'b1);
    send_pair(16'hFFFF, 16'h7FFF);
    send_pair(16'hF000, 16'h8000);
    send_pair(16'h7FFF, 16'h0000);
    wait_idle();

    // Smallest gain with dead band: a negative sum under one count stays reverse.
    set_config(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0FFF, 16'd77, 1'b0);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'hF000, 16'h0000);
    send_pair(16'h1000, 16'h0000);
    wait_idle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin  // moderate gains, wide output range
          gp  = 16'($urandom_range(0, 1023) - 512);
          gi  = 16'($urandom_range(0, 1023) - 512);
          gd  = 16'($urandom_range(0, 1023) - 512);
          il  = 16'($urandom_range(0, 32767));
          dl  = 16'h0FFF;
          dof = 16'($urandom_range(0, 255));
        end
        1: begin  // anything goes, wide bits included
          gp  = 16'($urandom);
          gi  = 16'($urandom);
          gd  = 16'($urandom);
          il  = 16'($urandom);
          dl  = 16'($urandom);
          dof = 16'($urandom);
        end
        2: begin  // small gains and tight clamps
          gp  = 16'($urandom_range(0, 128) - 64);
          gi  = 16'($urandom_range(0, 128) - 64);
          gd  = 16'($urandom_range(0, 128) - 64);
          il  = 16'($urandom_range(0, 200));
          dl  = 16'($urandom_range(0, 200));
          dof = 16'h0000;
        end
        default: begin  // register extremes
          gp  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          gi  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          gd  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          il  = $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
          dl  = $urandom_range(0, 1) ? 16'h0FFF : 16'h0000;
          dof = $urandom_range(0, 1) ? 16'h0FFF : 16'h0000;
        end
      endcase
      set_config(gp, gi, gd, il, dl, dof, (p % 4) == 1);
      push_up = 1'($urandom_range(0, 1));
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // mid-phase the sender waits for the pipe to run dry
        if (n == PhaseItems / 2) wait_idle();
        send_sample(rand_sample());
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_drive.size() == 0) begin
      $display("clamped_pid_motor_drive_unit test passed");
    end else begin
      $display("clamped_pid_motor_drive_unit test failed");
    end
    $finish;
  end

endmodule
